// ===== src/msvf_pkg.sv =====
package msvf_pkg;

	// config register indexes
	localparam logic [3:0] CFG_FILTER_MODE = 4'd0;
	localparam logic [3:0] CFG_RESONANCE   = 4'd1;
	localparam logic [3:0] CFG_CLIP_ENABLE = 4'd2;
	localparam logic [3:0] CFG_CLIP_BOOST  = 4'd3;

	// filter mode codes
	localparam logic [2:0] MODE_NONE     = 3'd0;
	localparam logic [2:0] MODE_ONEPOLE  = 3'd1;
	localparam logic [2:0] MODE_RESONANT = 3'd2;
	localparam logic [2:0] MODE_SVF_LP   = 3'd3;
	localparam logic [2:0] MODE_SVF_HP   = 3'd4;
	localparam logic [2:0] MODE_SVF_BP   = 3'd5;
	localparam logic [2:0] MODE_SVF_NOTCH = 3'd6;

	// q1.16 one, reciprocal of ten scaled by 2^24 (rounded up)
	localparam logic [16:0] ONE16     = 17'd65536;
	localparam logic [20:0] RECIP10   = 21'd1677722;
	localparam logic [16:0] DAMP_MAX  = 17'd117965;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_M1_MUL,
		ST_M1_ACC,
		ST_R_MUL1,
		ST_R_ACC1,
		ST_R_MUL2,
		ST_R_ACC2,
		ST_S_DMUL,
		ST_S_TMUL,
		ST_S_HMUL,
		ST_S_HACC,
		ST_S_BMUL,
		ST_S_BACC,
		ST_S_SEL,
		ST_CLIP_MUL,
		ST_CLIP_ACC,
		ST_FIN
	} state_t;

endpackage

// ===== src/multimode_svf_with_clip_top.sv =====
// Multimode audio filter with optional hard clip. One sample per request on the s_ side,
// one result per sample on the m_ side (tlast follows the sample). Filter state (low, high,
// band, Q5.18, saturating) is shared between modes; cutoff and amp limit come with every
// sample. All arithmetic runs on one 25x21-bit multiplier driven by a small sequencer, and
// s_tready is high only while the sequencer is idle, so a new sample is taken only once the
// last one has reached the output register. Each multiply has an issue state and a following
// state that takes its registered product, the clip adds one more multiply, and the
// state-variable modes spend one extra multiply to form the damping from the resonance.
// A finished sample waits in the output register so the next one can be accepted before
// the result is taken. Config writes are always taken (cfg_ready tied high) and must only be
// issued while the block is idle.
module multimode_svf_with_clip_top (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input samples
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // sample_in[17:0], cutoff[34:18], amp_limit[51:35], zero pad
	input  logic        s_tlast,   // end_of_buffer
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // sample_out[17:0], zero pad
	output logic        m_tlast    // last
);

	// rounding shift by 16, ties toward plus infinity
	function automatic logic signed [25:0] rnd16(input logic signed [41:0] p);
		logic signed [41:0] s;
		s = p + 42'sd32768;
		return s[41:16];
	endfunction

	// saturate to the q5.18 state range
	function automatic logic signed [23:0] sat_st(input logic signed [27:0] v);
		logic signed [23:0] r;
		if (v > 28'sd8388607) begin
			r = 24'sh7fffff;
		end else if (v < -28'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	// config registers
	logic [2:0]  mode_q;
	logic [15:0] res_q;
	logic        clip_en_q;
	logic [7:0]  boost_q;

	// filter state
	logic signed [23:0] low_q;
	logic signed [23:0] high_q;
	logic signed [23:0] band_q;

	// per-sample working registers
	logic signed [23:0] x_q;       // input in q5.18
	logic [16:0]        c_q;       // cutoff, saturated to 1.0
	logic [16:0]        a_q;       // amp limit, saturated to 1.0
	logic               last_q;
	logic signed [24:0] tmp_q;     // resonant y or svf t
	logic [16:0]        d_q;       // damping q1.16
	logic signed [23:0] v_q;       // value on its way to the output
	logic signed [41:0] prod_q;    // shared multiplier result

	// output register
	logic               out_valid_q;
	logic [17:0]        out_data_q;
	logic               out_last_q;

	msvf_pkg::state_t state_q, state_next;

	// sequencer outputs
	logic signed [24:0] mul_a;
	logic [20:0]        mul_b;
	logic signed [46:0] mul_full;
	logic               out_load;
	logic               in_accept;
	logic               cfg_accept;

	// input unpack
	logic [17:0] in_sample;
	logic [16:0] in_cutoff;
	logic [16:0] in_amp;
	logic signed [23:0] in_x;

	assign in_sample = s_tdata[17:0];
	assign in_cutoff = s_tdata[34:18];
	assign in_amp    = s_tdata[51:35];
	assign in_x      = {{2{in_sample[17]}}, in_sample, 4'b0000};

	assign in_accept  = s_tvalid && s_tready;
	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid && cfg_ready;

	// damping numerator 18*(1-r)+5 for the divide by ten
	logic [16:0] one_minus_r;
	logic [20:0] damp_num;
	assign one_minus_r = msvf_pkg::ONE16 - {1'b0, res_q};
	assign damp_num = 21'({one_minus_r, 4'b0000}) + 21'({one_minus_r, 1'b0}) + 21'd5;

	// clip gain 2*(1+boost)
	logic [9:0] gain;
	assign gain = {9'({1'b0, boost_q}) + 9'd1, 1'b0};

	// svf low clamp bound 4*amp
	logic signed [24:0] bound;
	assign bound = 25'({a_q, 2'b00});

	// result after rounding of the current product
	logic signed [25:0] prod_rnd;
	assign prod_rnd = rnd16(prod_q);

	// shared multiplier, registered below
	assign mul_full = mul_a * $signed({1'b0, mul_b});

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msvf_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state and multiplier operand selection
	always_comb begin
		state_next = state_q;
		mul_a      = '0;
		mul_b      = '0;
		s_tready   = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			msvf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (mode_q)
						msvf_pkg::MODE_ONEPOLE:  state_next = msvf_pkg::ST_M1_MUL;
						msvf_pkg::MODE_RESONANT: state_next = msvf_pkg::ST_R_MUL1;
						msvf_pkg::MODE_SVF_LP,
						msvf_pkg::MODE_SVF_HP,
						msvf_pkg::MODE_SVF_BP,
						msvf_pkg::MODE_SVF_NOTCH: state_next = msvf_pkg::ST_S_DMUL;
						default: begin
							// pass-through, unused code too
							state_next = clip_en_q ? msvf_pkg::ST_CLIP_MUL : msvf_pkg::ST_FIN;
						end
					endcase
				end
			end
			// one-pole: low + c*(x-low)
			msvf_pkg::ST_M1_MUL: begin
				mul_a      = 25'(x_q) - 25'(low_q);
				mul_b      = 21'(c_q);
				state_next = msvf_pkg::ST_M1_ACC;
			end
			msvf_pkg::ST_M1_ACC: begin
				state_next = clip_en_q ? msvf_pkg::ST_CLIP_MUL : msvf_pkg::ST_FIN;
			end
			// resonant one-pole: y = high + c*(x-high), then y + r*(y-band)
			msvf_pkg::ST_R_MUL1: begin
				mul_a      = 25'(x_q) - 25'(high_q);
				mul_b      = 21'(c_q);
				state_next = msvf_pkg::ST_R_ACC1;
			end
			msvf_pkg::ST_R_ACC1: begin
				state_next = msvf_pkg::ST_R_MUL2;
			end
			msvf_pkg::ST_R_MUL2: begin
				mul_a      = tmp_q - 25'(band_q);
				mul_b      = 21'(res_q);
				state_next = msvf_pkg::ST_R_ACC2;
			end
			msvf_pkg::ST_R_ACC2: begin
				state_next = clip_en_q ? msvf_pkg::ST_CLIP_MUL : msvf_pkg::ST_FIN;
			end
			// svf: damping = (18*(1-r)+5)/10 by reciprocal
			msvf_pkg::ST_S_DMUL: begin
				mul_a      = $signed({4'b0000, damp_num});
				mul_b      = msvf_pkg::RECIP10;
				state_next = msvf_pkg::ST_S_TMUL;
			end
			msvf_pkg::ST_S_TMUL: begin
				mul_a      = 25'(band_q);
				mul_b      = 21'(c_q);
				state_next = msvf_pkg::ST_S_HMUL;
			end
			msvf_pkg::ST_S_HMUL: begin
				mul_a      = 25'(band_q);
				mul_b      = 21'(d_q);
				state_next = msvf_pkg::ST_S_HACC;
			end
			msvf_pkg::ST_S_HACC: begin
				state_next = msvf_pkg::ST_S_BMUL;
			end
			msvf_pkg::ST_S_BMUL: begin
				mul_a      = 25'(high_q);
				mul_b      = 21'(c_q);
				state_next = msvf_pkg::ST_S_BACC;
			end
			msvf_pkg::ST_S_BACC: begin
				state_next = msvf_pkg::ST_S_SEL;
			end
			msvf_pkg::ST_S_SEL: begin
				state_next = clip_en_q ? msvf_pkg::ST_CLIP_MUL : msvf_pkg::ST_FIN;
			end
			// clip gain
			msvf_pkg::ST_CLIP_MUL: begin
				mul_a      = 25'(v_q);
				mul_b      = 21'(gain);
				state_next = msvf_pkg::ST_CLIP_ACC;
			end
			msvf_pkg::ST_CLIP_ACC: begin
				state_next = msvf_pkg::ST_FIN;
			end
			// hand over once the output register is free
			msvf_pkg::ST_FIN: begin
				if (!out_valid_q || m_tready) begin
					out_load   = 1'b1;
					state_next = msvf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = msvf_pkg::ST_IDLE;
			end
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= msvf_pkg::MODE_NONE;
			res_q     <= '0;
			clip_en_q <= 1'b0;
			boost_q   <= '0;
		end else if (cfg_accept) begin
			unique case (cfg_index)
				msvf_pkg::CFG_FILTER_MODE: mode_q    <= cfg_data[2:0];
				msvf_pkg::CFG_RESONANCE:   res_q     <= cfg_data;
				msvf_pkg::CFG_CLIP_ENABLE: clip_en_q <= cfg_data[0];
				msvf_pkg::CFG_CLIP_BOOST:  boost_q   <= cfg_data[7:0];
				default: ;  // unknown index, dropped
			endcase
		end
	end

	// new values of the filter state
	logic signed [23:0] onepole_y;
	logic signed [23:0] res_y1;
	logic signed [23:0] res_y2;
	logic signed [23:0] svf_high;
	logic signed [23:0] svf_band;
	logic signed [23:0] svf_low;
	logic signed [23:0] svf_out;

	assign onepole_y = sat_st(28'(low_q) + 28'(prod_rnd));
	assign res_y1    = sat_st(28'(high_q) + 28'(prod_rnd));
	assign res_y2    = sat_st(28'(tmp_q) + 28'(prod_rnd));
	assign svf_high  = sat_st(28'(x_q) - 28'(low_q) - 28'(prod_rnd));
	assign svf_band  = sat_st(28'(band_q) + 28'(prod_rnd));

	always_comb begin
		if (tmp_q > bound) begin
			svf_low = 24'(bound);
		end else if (tmp_q < -bound) begin
			svf_low = 24'(-bound);
		end else begin
			svf_low = tmp_q[23:0];
		end
	end

	always_comb begin
		unique case (mode_q)
			msvf_pkg::MODE_SVF_HP: svf_out = high_q;
			msvf_pkg::MODE_SVF_BP: svf_out = band_q;
			msvf_pkg::MODE_SVF_NOTCH: svf_out = sat_st(28'(low_q) + 28'(high_q));
			default: svf_out = low_q;
		endcase
	end

	// filter state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			band_q <= '0;
		end else begin
			unique case (state_q)
				msvf_pkg::ST_M1_ACC: begin
					low_q <= onepole_y;
				end
				msvf_pkg::ST_R_ACC2: begin
					band_q <= high_q;
					high_q <= res_y2;
					low_q  <= res_y2;
				end
				msvf_pkg::ST_S_HACC: begin
					high_q <= svf_high;
				end
				msvf_pkg::ST_S_BACC: begin
					band_q <= svf_band;
					low_q  <= svf_low;
				end
				default: ;
			endcase
		end
	end

	// final conversion q5.18 -> q3.14 with rounding and saturation
	logic signed [24:0] v_rnd;
	logic signed [20:0] v_q14;
	logic [17:0]        v_out;
	assign v_rnd = 25'(v_q) + 25'sd8;
	assign v_q14 = v_rnd[24:4];
	always_comb begin
		if (v_q14 > 21'sd131071) begin
			v_out = 18'h1ffff;
		end else if (v_q14 < -21'sd131072) begin
			v_out = 18'h20000;
		end else begin
			v_out = v_q14[17:0];
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= mul_full[41:0];
		if (in_accept) begin
			x_q    <= in_x;
			c_q    <= (in_cutoff > msvf_pkg::ONE16) ? msvf_pkg::ONE16 : in_cutoff;
			a_q    <= (in_amp > msvf_pkg::ONE16) ? msvf_pkg::ONE16 : in_amp;
			last_q <= s_tlast;
			v_q    <= in_x;
		end
		unique case (state_q)
			msvf_pkg::ST_M1_ACC:  v_q   <= onepole_y;
			msvf_pkg::ST_R_ACC1:  tmp_q <= 25'(res_y1);
			msvf_pkg::ST_R_ACC2:  v_q   <= res_y2;
			msvf_pkg::ST_S_TMUL:  d_q   <= prod_q[40:24];
			msvf_pkg::ST_S_HMUL:  tmp_q <= 25'(low_q) + 25'(prod_rnd);
			msvf_pkg::ST_S_SEL:   v_q   <= svf_out;
			msvf_pkg::ST_CLIP_ACC: begin
				if (prod_q > 42'sd262144) begin
					v_q <= 24'sd262144;
				end else if (prod_q < -42'sd262144) begin
					v_q <= -24'sd262144;
				end else begin
					v_q <= prod_q[23:0];
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= v_out;
			out_last_q <= last_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b000000, out_data_q};
	assign m_tlast  = out_last_q;

	// an accepted sample always starts the sequencer
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q != msvf_pkg::ST_IDLE)
		else $error("sequencer stayed idle after a request");

	// damping from the reciprocal multiply never exceeds 1.8
	a_damp_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == msvf_pkg::ST_S_TMUL |=> d_q <= msvf_pkg::DAMP_MAX)
		else $error("damping out of range");

	// svf low state stays inside plus or minus four times the largest amp limit
	a_low_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == msvf_pkg::ST_S_BACC |=>
			(low_q <= 24'sd262144 && low_q >= -24'sd262144))
		else $error("svf low state escaped its clamp");

	// with the clip on, the output stays within plus or minus one
	a_clip_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && clip_en_q |=>
			($signed(m_tdata[17:0]) <= 18'sd16384 && $signed(m_tdata[17:0]) >= -18'sd16384))
		else $error("clipped output beyond unity");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	// mode code the block leaves unnamed, behaves as pass-through
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	// first register index past the defined ones, writes there are dropped
	localparam logic [3:0] CFG_FIRST_UNUSED = 4'd4;
	// settle time before a register write, above the worst request-to-request time
	localparam int IDLE_GAP = 16;
	localparam int NUM_PHASES = 24;
	localparam int PHASE_ITEMS = 64;
	localparam int NUM_DIRECTED = 23;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;    // sample_in[17:0], cutoff[34:18], amp_limit[51:35], zero pad
	logic        s_tlast = 1'b0;  // end_of_buffer
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // sample_out[17:0], zero pad
	logic        m_tlast;         // last

	multimode_svf_with_clip_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hard stop well past the slowest legal run
	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	// one filtered sample as it should leave the block
	typedef struct packed {
		logic signed [17:0] smp;
		logic               last;
	} filt_out_t;

	// one directed request: settings it runs under, the sample, and an optional
	// hand-worked answer
	typedef struct packed {
		logic [2:0]         mode;
		logic [15:0]        reso;
		logic               clip;
		logic [7:0]         boost;
		logic signed [17:0] smp;
		logic [16:0]        cut;
		logic [16:0]        amp;
		logic               eob;
		logic               typed;
		logic signed [17:0] want;
	} dir_row_t;

	dir_row_t directed_rows [NUM_DIRECTED] = '{
		// pass-through right after reset, full-scale and zero, cutoff/amp ignored
		'{msvf_pkg::MODE_NONE, 16'd0, 1'b0, 8'd0, 18'sd131071,
			17'd0, 17'd0, 1'b0, 1'b1, 18'sd131071},
		'{msvf_pkg::MODE_NONE, 16'd0, 1'b0, 8'd0, -18'sd131072,
			17'd65536, 17'd65536, 1'b1, 1'b1, -18'sd131072},
		'{msvf_pkg::MODE_NONE, 16'd0, 1'b0, 8'd0, 18'sd0,
			17'd131071, 17'd131071, 1'b0, 1'b1, 18'sd0},
		// unused mode code passes the sample untouched
		'{MODE_UNUSED, 16'd0, 1'b0, 8'd0, 18'sd12345,
			17'd131071, 17'd131071, 1'b1, 1'b1, 18'sd12345},
		// clip at minimum gain saturates full scale to plus or minus one
		'{msvf_pkg::MODE_NONE, 16'd0, 1'b1, 8'd0, 18'sd131071,
			17'd0, 17'd0, 1'b0, 1'b1, 18'sd16384},
		'{msvf_pkg::MODE_NONE, 16'd0, 1'b1, 8'd0, -18'sd131072,
			17'd0, 17'd0, 1'b0, 1'b1, -18'sd16384},
		// maximum gain on the smallest nonzero samples
		'{msvf_pkg::MODE_NONE, 16'd0, 1'b1, 8'd255, 18'sd1,
			17'd0, 17'd0, 1'b0, 1'b1, 18'sd512},
		'{msvf_pkg::MODE_NONE, 16'd0, 1'b1, 8'd255, -18'sd1,
			17'd0, 17'd0, 1'b1, 1'b1, -18'sd512},
		// one-pole at unity cutoff follows the input exactly, zero cutoff holds
		'{msvf_pkg::MODE_ONEPOLE, 16'd0, 1'b0, 8'd0, 18'sd131071,
			17'd65536, 17'd0, 1'b0, 1'b1, 18'sd131071},
		'{msvf_pkg::MODE_ONEPOLE, 16'd0, 1'b0, 8'd0, -18'sd5000,
			17'd0, 17'd0, 1'b0, 1'b0, 18'sd0},
		// cutoff above one saturates to one
		'{msvf_pkg::MODE_ONEPOLE, 16'd0, 1'b0, 8'd0, 18'sd77777,
			17'd131071, 17'd0, 1'b1, 1'b1, 18'sd77777},
		'{msvf_pkg::MODE_RESONANT, 16'd0, 1'b0, 8'd0, 18'sd40000,
			17'd30000, 17'd0, 1'b0, 1'b0, 18'sd0},
		'{msvf_pkg::MODE_RESONANT, 16'd65535, 1'b0, 8'd0, -18'sd90000,
			17'd65536, 17'd0, 1'b0, 1'b0, 18'sd0},
		'{msvf_pkg::MODE_RESONANT, 16'd65535, 1'b0, 8'd0, 18'sd131071,
			17'd131071, 17'd0, 1'b1, 1'b0, 18'sd0},
		'{msvf_pkg::MODE_SVF_LP, 16'd0, 1'b0, 8'd0, 18'sd100000,
			17'd65536, 17'd65536, 1'b0, 1'b0, 18'sd0},
		// zero amp limit pins the lowpass state at zero
		'{msvf_pkg::MODE_SVF_LP, 16'd0, 1'b0, 8'd0, -18'sd131072,
			17'd65536, 17'd0, 1'b0, 1'b1, 18'sd0},
		'{msvf_pkg::MODE_SVF_HP, 16'd65535, 1'b0, 8'd0, 18'sd131071,
			17'd131071, 17'd131071, 1'b0, 1'b0, 18'sd0},
		'{msvf_pkg::MODE_SVF_HP, 16'd0, 1'b0, 8'd0, -18'sd131072,
			17'd0, 17'd65536, 1'b1, 1'b0, 18'sd0},
		'{msvf_pkg::MODE_SVF_BP, 16'd32768, 1'b0, 8'd0, 18'sd50000,
			17'd20000, 17'd40000, 1'b0, 1'b0, 18'sd0},
		'{msvf_pkg::MODE_SVF_BP, 16'd65535, 1'b1, 8'd255, -18'sd70000,
			17'd65536, 17'd65536, 1'b0, 1'b0, 18'sd0},
		'{msvf_pkg::MODE_SVF_NOTCH, 16'd0, 1'b0, 8'd0, 18'sd131071,
			17'd65536, 17'd65536, 1'b0, 1'b0, 18'sd0},
		'{msvf_pkg::MODE_SVF_NOTCH, 16'd65535, 1'b1, 8'd0, -18'sd131072,
			17'd131071, 17'd131071, 1'b1, 1'b0, 18'sd0},
		'{msvf_pkg::MODE_SVF_NOTCH, 16'd12345, 1'b1, 8'd255, 18'sd3,
			17'd100, 17'd200, 1'b0, 1'b0, 18'sd0}
	};

	// shadow copy of the register file and the filter memory
	logic [2:0]         mode_q = msvf_pkg::MODE_NONE;
	logic [15:0]        reso_q = '0;
	logic               clip_q = 1'b0;
	logic [7:0]         boost_q = '0;
	logic signed [23:0] lp_st = '0;
	logic signed [23:0] hp_st = '0;
	logic signed [23:0] bp_st = '0;

	filt_out_t expected_out [$];
	filt_out_t head_out;
	int        err_count = 0;
	int        burst_left = 0;

	function automatic longint clampl(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// shift right with round to nearest, ties toward plus infinity
	function automatic longint rnd_shr(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic logic signed [23:0] sat_state(longint v);
		return 24'(clampl(v, -64'sd8388608, 64'sd8388607));
	endfunction

	// advances the shadow filter by one sample and returns what should come out
	function automatic filt_out_t filter_sample(logic signed [17:0] smp, logic [16:0] cut,
			logic [16:0] amp, logic eob);
		longint    x, c, a, r, v, y, t, damp, bnd;
		filt_out_t res;
		x = longint'(smp) * 16;
		c = (cut > msvf_pkg::ONE16) ? longint'(msvf_pkg::ONE16) : longint'(cut);
		a = (amp > msvf_pkg::ONE16) ? longint'(msvf_pkg::ONE16) : longint'(amp);
		r = longint'(reso_q);
		case (mode_q)
		msvf_pkg::MODE_ONEPOLE: begin
			lp_st = sat_state(rnd_shr(c * x + (65536 - c) * longint'(lp_st), 16));
			v = longint'(lp_st);
		end
		msvf_pkg::MODE_RESONANT: begin
			y = longint'(sat_state(rnd_shr(c * x + (65536 - c) * longint'(hp_st), 16)));
			y = longint'(sat_state(y + rnd_shr((y - longint'(bp_st)) * r, 16)));
			bp_st = hp_st;
			hp_st = 24'(y);
			lp_st = 24'(y);
			v = y;
		end
		msvf_pkg::MODE_SVF_LP, msvf_pkg::MODE_SVF_HP, msvf_pkg::MODE_SVF_BP,
		msvf_pkg::MODE_SVF_NOTCH: begin
			// damping 1.8*(1-r), rounded with ties up
			damp = (18 * (65536 - r) + 5) / 10;
			t = longint'(lp_st) + rnd_shr(c * longint'(bp_st), 16);
			bnd = 4 * a;
			hp_st = sat_state(x - longint'(lp_st) - rnd_shr(damp * longint'(bp_st), 16));
			bp_st = sat_state(longint'(bp_st) + rnd_shr(c * longint'(hp_st), 16));
			lp_st = 24'(clampl(t, -bnd, bnd));
			case (mode_q)
			msvf_pkg::MODE_SVF_LP: v = longint'(lp_st);
			msvf_pkg::MODE_SVF_HP: v = longint'(hp_st);
			msvf_pkg::MODE_SVF_BP: v = longint'(bp_st);
			default:               v = longint'(sat_state(longint'(lp_st) + longint'(hp_st)));
			endcase
		end
		default: v = x;  // pass-through, also the unused code
		endcase
		if (clip_q)
			v = clampl(v * (2 * (1 + longint'(boost_q))), -64'sd262144, 64'sd262144);
		res.smp = 18'(clampl(rnd_shr(v, 4), -64'sd131072, 64'sd131071));
		res.last = eob;
		return res;
	endfunction

	// one register write request; the shadow copy follows on acceptance
	task automatic cfg_write(input logic [3:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
		msvf_pkg::CFG_FILTER_MODE: mode_q = data[2:0];
		msvf_pkg::CFG_RESONANCE:   reso_q = data;
		msvf_pkg::CFG_CLIP_ENABLE: clip_q = data[0];
		msvf_pkg::CFG_CLIP_BOOST:  boost_q = data[7:0];
		default: ;
		endcase
	endtask

	// stop sending, let every result drain, then give the sequencer time to settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	// retune the block between phases; upper data bits may carry junk that must be masked
	task automatic retune(input logic [15:0] mode_word, input logic [15:0] reso_word,
			input logic [15:0] clip_word, input logic [15:0] boost_word, input bit write_all);
		if (write_all || mode_word[2:0] != mode_q || reso_word != reso_q ||
				clip_word[0] != clip_q || boost_word[7:0] != boost_q) begin
			wait_idle();
			if (write_all || mode_word[2:0] != mode_q)
				cfg_write(msvf_pkg::CFG_FILTER_MODE, mode_word);
			if (write_all || reso_word != reso_q)
				cfg_write(msvf_pkg::CFG_RESONANCE, reso_word);
			// a stray write to an undefined index now and then, must change nothing
			if (write_all && $urandom_range(0, 1) == 0)
				cfg_write(CFG_FIRST_UNUSED + 4'($urandom_range(0, 11)), 16'($urandom));
			if (write_all || clip_word[0] != clip_q)
				cfg_write(msvf_pkg::CFG_CLIP_ENABLE, clip_word);
			if (write_all || boost_word[7:0] != boost_q)
				cfg_write(msvf_pkg::CFG_CLIP_BOOST, boost_word);
			cfg_valid <= 1'b0;
		end
	endtask

	// one sample request, sent in bursts with random gaps between them
	task automatic send_sample(input logic signed [17:0] smp, input logic [16:0] cut,
			input logic [16:0] amp, input logic eob, input logic typed,
			input logic signed [17:0] want);
		int        gap;
		filt_out_t res;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, amp, cut, smp};
		s_tlast  <= eob;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		res = filter_sample(smp, cut, amp, eob);
		if (typed)
			res.smp = want;
		expected_out.push_back(res);
	endtask

	// result side: random stall pattern, reshuffled at regular intervals, sometimes no stalls at all
	logic [15:0] stall_mask = 16'hFFFF;
	int unsigned stall_tick = 0;

	always @(posedge clk) begin
		if (stall_tick % 64 == 0) begin
			if ($urandom_range(0, 3) == 0)
				stall_mask = 16'hFFFF;
			else
				stall_mask = 16'($urandom) | 16'h0001;
		end
		m_tready <= stall_mask[stall_tick % 16];
		stall_tick++;
	end

	// result checker, compares each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected result sample_out=%0d last=%0b", $time,
					$signed(m_tdata[17:0]), m_tlast);
				err_count++;
			end else begin
				head_out = expected_out.pop_front();
				if ($signed(m_tdata[17:0]) !== head_out.smp) begin
					$display("%0t: sample_out expected %0d actual %0d", $time, head_out.smp,
						$signed(m_tdata[17:0]));
					err_count++;
				end
				if (m_tlast !== head_out.last) begin
					$display("%0t: last expected %0b actual %0b", $time, head_out.last,
						m_tlast);
					err_count++;
				end
			end
		end
	end

	initial begin
		int                 phase, k, style, half;
		logic [2:0]         mode;
		logic [15:0]        reso;
		logic               clip;
		logic [7:0]         boost;
		logic signed [17:0] smp, level;
		logic [16:0]        cut, amp, cut_base, amp_base;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: extremes, every mode, the listed corner cases
		for (k = 0; k < NUM_DIRECTED; k++) begin
			retune({13'd0, directed_rows[k].mode}, directed_rows[k].reso,
				{15'd0, directed_rows[k].clip}, {8'd0, directed_rows[k].boost}, 1'b0);
			send_sample(directed_rows[k].smp, directed_rows[k].cut, directed_rows[k].amp,
				directed_rows[k].eob, directed_rows[k].typed, directed_rows[k].want);
		end

		// random phases, filter memory carried across mode changes
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			k = $urandom_range(0, 15);
			mode = (k < 8) ? 3'(k) : msvf_pkg::MODE_SVF_LP + 3'(k % 4);
			case ($urandom_range(0, 3))
			0:       reso = 16'd0;
			1:       reso = 16'hFFFF;
			default: reso = 16'($urandom);
			endcase
			clip = ($urandom_range(0, 2) == 0);
			case ($urandom_range(0, 3))
			0:       boost = 8'd0;
			1:       boost = 8'd255;
			2:       boost = 8'($urandom_range(0, 7));
			default: boost = 8'($urandom);
			endcase
			retune({13'($urandom), mode}, reso, {15'($urandom), clip}, {8'($urandom), boost},
				1'b1);

			case ($urandom_range(0, 4))
			0:       cut_base = 17'd0;
			1:       cut_base = msvf_pkg::ONE16;
			2:       cut_base = 17'($urandom_range(65537, 131071));
			3:       cut_base = 17'($urandom_range(0, 65536));
			default: cut_base = 17'($urandom_range(0, 4000));
			endcase
			amp_base = ($urandom_range(0, 3) == 0) ? 17'($urandom)
				: 17'($urandom_range(0, 65536));
			style = $urandom_range(0, 3);
			half = $urandom_range(1, 20);
			level = 18'($urandom_range(0, 131071));

			for (k = 0; k < PHASE_ITEMS; k++) begin
				case (style)
				0: smp = 18'($urandom);
				1: smp = 18'(int'($urandom_range(0, 4095)) - 2048);
				// square wave drives the resonant and svf paths toward their limits
				2: smp = ((k / half) % 2) ? level : -level;
				default: begin
					case ($urandom_range(0, 2))
					0:       smp = 18'sd131071;
					1:       smp = -18'sd131072;
					default: smp = 18'sd0;
					endcase
				end
				endcase
				cut = ($urandom_range(0, 3) == 0) ? 17'($urandom) : cut_base;
				amp = ($urandom_range(0, 7) == 0) ? 17'($urandom) : amp_base;
				send_sample(smp, cut, amp, ($urandom_range(0, 15) == 0), 1'b0, 18'sd0);
			end
		end

		wait_idle();
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== multimode_svf_with_clip_top.f =====
src/msvf_pkg.sv
src/multimode_svf_with_clip_top.sv
verif/tb_top.sv
